### hdl/ffal_pkg.sv
// Shared types and constants for the first-fit free-list allocator.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`default_nettype none

package ffal_pkg;

    // Header fields (next index, size in units) and the heap-limit register are 14 bits.
    localparam int unsigned FW = 14;
    // Units requested plus the header unit; 15 bits holds the largest request.
    localparam int unsigned NUW = 15;
    localparam int unsigned BYTE_W = 16;

    localparam int unsigned HEAP_UNITS_DEF = 8192;
    localparam int unsigned UNIT_BYTES_DEF = 8;
    localparam logic [FW-1:0] LIMIT_RESET = FW'(8192);

    // Division by the unit size is done as a multiply by a scaled reciprocal.
    localparam int unsigned MULX_W = 17;
    localparam int unsigned RECIP_W = 20;
    localparam int unsigned PROD_W = MULX_W + RECIP_W;
    localparam int unsigned DIV_SHIFT = 21;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_NULL = 2'd1,
        ST_OOM  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_ALC_P,
        S_ALC_CHK,
        S_ALC_SPLIT2,
        S_ALC_RET,
        S_F_INIT,
        S_F_WALK,
        S_F_M2,
        S_F_M3,
        S_F_M5,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        C_NONE,
        C_CAPTURE,
        C_MUL,
        C_NULL,
        C_ALC_START,
        C_ALC_NEXT,
        C_ALC_TAKE,
        C_ALC_SPLIT1,
        C_ALC_SPLIT2,
        C_ALC_OOM,
        C_ALC_GROW,
        C_ALC_STEP,
        C_ALC_REWALK,
        C_FREE_START,
        C_F_INIT,
        C_F_ADV,
        C_F_M1,
        C_F_M2A,
        C_F_M2B,
        C_F_M3,
        C_F_M5,
        C_F_FAIL,
        C_LOAD_OUT
    } t_op;

    typedef struct packed {
        logic is_free;
        logic req_zero;
        logic free_bad;
        logic fits;
        logic exact;
        logic at_rover;
        logic grow_fail;
        logic steps_last;
        logic fsteps_last;
        logic walk_stop;
        logic merge_next;
    } t_dp_status;

    // Address order key: the sentinel sorts below every heap unit.
    function automatic logic [FW:0] order_key(input logic [FW-1:0] x,
                                              input logic [FW-1:0] sent);
        logic [FW:0] k;
        k = (x == sent) ? '0 : ({1'b0, x} + (FW+1)'(1));
        return k;
    endfunction

endpackage

`default_nettype wire

### hdl/ffal_dp.sv
// Datapath of the allocator: header memories, list pointers, arithmetic and result registers.
// Depends on ffal_pkg; driven by ffal_ctrl through an operation code.
`default_nettype none

module ffal_dp #(
    parameter int unsigned HEAP_UNITS = ffal_pkg::HEAP_UNITS_DEF,
    parameter int unsigned UNIT_BYTES = ffal_pkg::UNIT_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ffal_pkg::t_op                 i_op,
    output ffal_pkg::t_dp_status               o_st,
    input  wire logic                          i_func,
    input  wire logic [ffal_pkg::BYTE_W-1:0]   i_request_bytes,
    input  wire logic [ffal_pkg::BYTE_W-1:0]   i_free_offset,
    input  wire logic                          i_cfg_we,
    input  wire logic [ffal_pkg::FW-1:0]       i_cfg_data,
    output logic      [ffal_pkg::BYTE_W-1:0]   o_payload_offset,
    output logic      [1:0]                    o_status
);

    localparam int unsigned FW = ffal_pkg::FW;
    localparam int unsigned NUW = ffal_pkg::NUW;
    localparam int unsigned BW = ffal_pkg::BYTE_W;
    localparam int unsigned AW = $clog2(HEAP_UNITS);
    localparam int unsigned WALK_LIMIT = 2 * HEAP_UNITS + 4;
    localparam int unsigned SW = $clog2(WALK_LIMIT + 1);
    localparam logic [FW-1:0] SENT = FW'(HEAP_UNITS);
    localparam logic [FW:0] HEAP_X = (FW+1)'(HEAP_UNITS);
    localparam logic [ffal_pkg::RECIP_W-1:0] RECIP =
        ffal_pkg::RECIP_W'(((1 << ffal_pkg::DIV_SHIFT) + UNIT_BYTES - 1) / UNIT_BYTES);

    // Header storage, one next and one size word per heap unit.
    logic [FW-1:0] mem_next [HEAP_UNITS];
    logic [FW-1:0] mem_size [HEAP_UNITS];
    logic [FW-1:0] r_q_next, r_q_size, r_rd_node;

    logic                 r_func;
    logic [BW-1:0]        r_req, r_off;
    logic [ffal_pkg::PROD_W-1:0] r_prod;
    logic [NUW-1:0]       r_nunits;
    logic [FW-1:0]        r_prev, r_p, r_bp, r_nx, r_psz, r_bsz, r_bnext;
    logic [FW:0]          r_split;
    logic [SW-1:0]        r_steps, r_fsteps;
    logic [FW-1:0]        r_rover, r_sent_next, r_break, r_limit;
    logic [BW-1:0]        r_payload, r_out_payload;
    ffal_pkg::t_status    r_status, r_out_status;

    logic                 rd_en;
    logic [FW-1:0]        rd_node;
    logic                 wr_next_en, wr_size_en;
    logic [FW:0]          wr_node;
    logic [FW-1:0]        wr_next, wr_size;

    logic [FW-1:0]        hdr_next, hdr_size;
    logic [BW-1:0]        quot;
    logic [FW-1:0]        unit, unit_m1, lim_eff, newsz, msum;
    logic [ffal_pkg::MULX_W-1:0] mul_x;
    logic                 merge_prev;
    logic [FW:0]          kb, kp, kn;

    always_comb begin
        hdr_next = '0;
        if (r_rd_node == SENT) begin
            hdr_next = r_sent_next;
        end else if ({1'b0, r_rd_node} < HEAP_X) begin
            hdr_next = r_q_next;
        end
        hdr_size = ({1'b0, r_rd_node} < HEAP_X) ? r_q_size : '0;
    end

    assign quot    = r_prod[ffal_pkg::DIV_SHIFT +: BW];
    assign unit    = quot[FW-1:0];
    assign unit_m1 = unit - FW'(1);
    assign lim_eff = ({1'b0, r_limit} > HEAP_X) ? SENT : r_limit;
    assign newsz   = hdr_size - r_nunits[FW-1:0];
    assign msum    = r_bsz + hdr_size;
    assign mul_x   = r_func ? {1'b0, r_off}
                            : ({1'b0, r_req} + ffal_pkg::MULX_W'(UNIT_BYTES - 1));
    assign merge_prev = (r_p != SENT) && (({1'b0, r_p} + {1'b0, r_psz}) == {1'b0, r_bp});
    assign kb = ffal_pkg::order_key(r_bp, SENT);
    assign kp = ffal_pkg::order_key(r_p, SENT);
    assign kn = ffal_pkg::order_key(hdr_next, SENT);

    always_comb begin
        o_st.is_free     = r_func;
        o_st.req_zero    = (r_req == '0);
        o_st.free_bad    = (unit == '0) || (unit_m1 >= r_break) || ({1'b0, unit_m1} >= HEAP_X);
        o_st.fits        = ({1'b0, hdr_size} >= r_nunits);
        o_st.exact       = ({1'b0, hdr_size} == r_nunits);
        o_st.at_rover    = (r_p == r_rover);
        o_st.grow_fail   = ((BW'(r_break) + BW'(r_nunits)) > BW'(lim_eff));
        o_st.steps_last  = (r_steps == SW'(WALK_LIMIT));
        o_st.fsteps_last = (r_fsteps == SW'(WALK_LIMIT));
        o_st.walk_stop   = ((kb > kp) && (kb < kn)) || ((kp >= kn) && ((kb > kp) || (kb < kn)));
        o_st.merge_next  = (r_nx != SENT) &&
                           (({1'b0, r_bp} + {1'b0, hdr_size}) == {1'b0, r_nx});
    end

    // Memory port control for the current operation.
    always_comb begin
        rd_en      = 1'b0;
        rd_node    = r_rover;
        wr_next_en = 1'b0;
        wr_size_en = 1'b0;
        wr_node    = {1'b0, r_bp};
        wr_next    = r_nx;
        wr_size    = hdr_size;
        case (i_op)
            ffal_pkg::C_ALC_START, ffal_pkg::C_ALC_REWALK, ffal_pkg::C_F_INIT: begin
                rd_en   = 1'b1;
                rd_node = r_rover;
            end
            ffal_pkg::C_ALC_NEXT, ffal_pkg::C_ALC_STEP, ffal_pkg::C_F_ADV: begin
                rd_en   = 1'b1;
                rd_node = hdr_next;
            end
            ffal_pkg::C_ALC_TAKE: begin
                wr_next_en = 1'b1;
                wr_node    = {1'b0, r_prev};
                wr_next    = hdr_next;
            end
            ffal_pkg::C_ALC_SPLIT1: begin
                wr_size_en = 1'b1;
                wr_node    = {1'b0, r_p};
                wr_size    = newsz;
            end
            ffal_pkg::C_ALC_SPLIT2: begin
                wr_size_en = 1'b1;
                wr_node    = r_split;
                wr_size    = r_nunits[FW-1:0];
            end
            ffal_pkg::C_ALC_GROW: begin
                wr_size_en = 1'b1;
                wr_node    = {1'b0, r_break};
                wr_size    = r_nunits[FW-1:0];
            end
            ffal_pkg::C_F_M1: begin
                rd_en   = 1'b1;
                rd_node = r_bp;
            end
            ffal_pkg::C_F_M2A: begin
                rd_en   = 1'b1;
                rd_node = r_nx;
            end
            ffal_pkg::C_F_M2B: begin
                wr_next_en = 1'b1;
                wr_node    = {1'b0, r_bp};
                wr_next    = r_nx;
            end
            ffal_pkg::C_F_M3: begin
                wr_next_en = 1'b1;
                wr_size_en = 1'b1;
                wr_node    = {1'b0, r_bp};
                wr_next    = hdr_next;
                wr_size    = msum;
            end
            ffal_pkg::C_F_M5: begin
                wr_next_en = 1'b1;
                wr_node    = {1'b0, r_p};
                if (merge_prev) begin
                    wr_size_en = 1'b1;
                    wr_size    = r_psz + r_bsz;
                    wr_next    = r_bnext;
                end else begin
                    wr_next    = r_bp;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_next_en && (wr_node < HEAP_X)) begin
            mem_next[wr_node[AW-1:0]] <= wr_next;
        end
        if (wr_size_en && (wr_node < HEAP_X)) begin
            mem_size[wr_node[AW-1:0]] <= wr_size;
        end
        if (rd_en) begin
            r_q_next  <= mem_next[rd_node[AW-1:0]];
            r_q_size  <= mem_size[rd_node[AW-1:0]];
            r_rd_node <= rd_node;
        end
    end

    // Persistent allocator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent_next <= SENT;
            r_rover     <= SENT;
            r_break     <= '0;
            r_limit     <= ffal_pkg::LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (wr_next_en && (wr_node == {1'b0, SENT})) begin
                r_sent_next <= wr_next;
            end
            case (i_op)
                ffal_pkg::C_ALC_TAKE, ffal_pkg::C_ALC_SPLIT2: r_rover <= r_prev;
                ffal_pkg::C_F_M5:     r_rover <= r_p;
                ffal_pkg::C_ALC_GROW: r_break <= r_break + r_nunits[FW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Working registers of one request.
    always_ff @(posedge i_clk) begin
        case (i_op)
            ffal_pkg::C_CAPTURE: begin
                r_func <= i_func;
                r_req  <= i_request_bytes;
                r_off  <= i_free_offset;
            end
            ffal_pkg::C_MUL: begin
                r_prod <= ffal_pkg::PROD_W'(mul_x) * ffal_pkg::PROD_W'(RECIP);
            end
            ffal_pkg::C_NULL, ffal_pkg::C_F_FAIL: begin
                r_payload <= '0;
                r_status  <= ffal_pkg::ST_NULL;
            end
            ffal_pkg::C_ALC_START: begin
                r_nunits <= NUW'(quot) + NUW'(1);
                r_prev   <= r_rover;
                r_steps  <= '0;
            end
            ffal_pkg::C_ALC_NEXT: begin
                r_p <= hdr_next;
            end
            ffal_pkg::C_ALC_TAKE: begin
                r_payload <= BW'((32'(r_p) + 32'd1) * 32'(UNIT_BYTES));
                r_status  <= ffal_pkg::ST_DONE;
            end
            ffal_pkg::C_ALC_SPLIT1: begin
                r_split <= {1'b0, r_p} + {1'b0, newsz};
            end
            ffal_pkg::C_ALC_SPLIT2: begin
                r_payload <= BW'((32'(r_split) + 32'd1) * 32'(UNIT_BYTES));
                r_status  <= ffal_pkg::ST_DONE;
            end
            ffal_pkg::C_ALC_OOM: begin
                r_payload <= '0;
                r_status  <= ffal_pkg::ST_OOM;
            end
            ffal_pkg::C_ALC_GROW: begin
                r_bp <= r_break;
            end
            ffal_pkg::C_ALC_STEP: begin
                r_steps <= r_steps + SW'(1);
                r_prev  <= r_p;
                r_p     <= hdr_next;
            end
            ffal_pkg::C_ALC_REWALK: begin
                r_steps <= r_steps + SW'(1);
                r_prev  <= r_rover;
            end
            ffal_pkg::C_FREE_START: begin
                r_bp <= unit_m1;
            end
            ffal_pkg::C_F_INIT: begin
                r_p      <= r_rover;
                r_fsteps <= '0;
            end
            ffal_pkg::C_F_ADV: begin
                r_p      <= hdr_next;
                r_fsteps <= r_fsteps + SW'(1);
            end
            ffal_pkg::C_F_M1: begin
                r_nx  <= hdr_next;
                r_psz <= hdr_size;
            end
            ffal_pkg::C_F_M2A: begin
                r_bsz <= hdr_size;
            end
            ffal_pkg::C_F_M2B: begin
                r_bsz   <= hdr_size;
                r_bnext <= r_nx;
            end
            ffal_pkg::C_F_M3: begin
                r_bsz   <= msum;
                r_bnext <= hdr_next;
            end
            ffal_pkg::C_F_M5: begin
                r_payload <= '0;
                r_status  <= ffal_pkg::ST_DONE;
            end
            ffal_pkg::C_LOAD_OUT: begin
                r_out_payload <= r_payload;
                r_out_status  <= r_status;
            end
            default: begin
            end
        endcase
    end

    assign o_payload_offset = r_out_payload;
    assign o_status         = r_out_status;

endmodule

`default_nettype wire

### hdl/ffal_ctrl.sv
// Controller of the allocator: sequences allocate, grow and free walks over the datapath.
// Depends on ffal_pkg; drives ffal_dp with one operation code per cycle.
`default_nettype none

module ffal_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    input  wire ffal_pkg::t_dp_status  i_st,
    output ffal_pkg::t_op              o_op
);

    ffal_pkg::t_state r_state, n_state;
    logic             r_from_alloc, r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ffal_pkg::S_IDLE;
            r_from_alloc <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_op == ffal_pkg::C_ALC_GROW) begin
                r_from_alloc <= 1'b1;
            end else if (o_op == ffal_pkg::C_FREE_START) begin
                r_from_alloc <= 1'b0;
            end
            if (o_op == ffal_pkg::C_LOAD_OUT) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = ffal_pkg::C_NONE;
        case (r_state)
            ffal_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_op    = ffal_pkg::C_CAPTURE;
                    n_state = ffal_pkg::S_DECODE;
                end
            end
            ffal_pkg::S_DECODE: begin
                o_op    = ffal_pkg::C_MUL;
                n_state = ffal_pkg::S_DIV;
            end
            ffal_pkg::S_DIV: begin
                if (i_st.is_free) begin
                    if (i_st.free_bad) begin
                        o_op    = ffal_pkg::C_NULL;
                        n_state = ffal_pkg::S_DONE;
                    end else begin
                        o_op    = ffal_pkg::C_FREE_START;
                        n_state = ffal_pkg::S_F_INIT;
                    end
                end else if (i_st.req_zero) begin
                    o_op    = ffal_pkg::C_NULL;
                    n_state = ffal_pkg::S_DONE;
                end else begin
                    o_op    = ffal_pkg::C_ALC_START;
                    n_state = ffal_pkg::S_ALC_P;
                end
            end
            ffal_pkg::S_ALC_P: begin
                o_op    = ffal_pkg::C_ALC_NEXT;
                n_state = ffal_pkg::S_ALC_CHK;
            end
            ffal_pkg::S_ALC_CHK: begin
                if (i_st.fits && i_st.exact) begin
                    o_op    = ffal_pkg::C_ALC_TAKE;
                    n_state = ffal_pkg::S_DONE;
                end else if (i_st.fits) begin
                    o_op    = ffal_pkg::C_ALC_SPLIT1;
                    n_state = ffal_pkg::S_ALC_SPLIT2;
                end else if (i_st.at_rover && i_st.grow_fail) begin
                    o_op    = ffal_pkg::C_ALC_OOM;
                    n_state = ffal_pkg::S_DONE;
                end else if (i_st.at_rover) begin
                    o_op    = ffal_pkg::C_ALC_GROW;
                    n_state = ffal_pkg::S_F_INIT;
                end else if (i_st.steps_last) begin
                    o_op    = ffal_pkg::C_ALC_OOM;
                    n_state = ffal_pkg::S_DONE;
                end else begin
                    o_op    = ffal_pkg::C_ALC_STEP;
                    n_state = ffal_pkg::S_ALC_CHK;
                end
            end
            ffal_pkg::S_ALC_SPLIT2: begin
                o_op    = ffal_pkg::C_ALC_SPLIT2;
                n_state = ffal_pkg::S_DONE;
            end
            ffal_pkg::S_ALC_RET: begin
                if (i_st.steps_last) begin
                    o_op    = ffal_pkg::C_ALC_OOM;
                    n_state = ffal_pkg::S_DONE;
                end else begin
                    o_op    = ffal_pkg::C_ALC_REWALK;
                    n_state = ffal_pkg::S_ALC_P;
                end
            end
            ffal_pkg::S_F_INIT: begin
                o_op    = ffal_pkg::C_F_INIT;
                n_state = ffal_pkg::S_F_WALK;
            end
            ffal_pkg::S_F_WALK: begin
                if (i_st.walk_stop) begin
                    o_op    = ffal_pkg::C_F_M1;
                    n_state = ffal_pkg::S_F_M2;
                end else if (i_st.fsteps_last) begin
                    o_op    = r_from_alloc ? ffal_pkg::C_NONE : ffal_pkg::C_F_FAIL;
                    n_state = r_from_alloc ? ffal_pkg::S_ALC_RET : ffal_pkg::S_DONE;
                end else begin
                    o_op    = ffal_pkg::C_F_ADV;
                    n_state = ffal_pkg::S_F_WALK;
                end
            end
            ffal_pkg::S_F_M2: begin
                if (i_st.merge_next) begin
                    o_op    = ffal_pkg::C_F_M2A;
                    n_state = ffal_pkg::S_F_M3;
                end else begin
                    o_op    = ffal_pkg::C_F_M2B;
                    n_state = ffal_pkg::S_F_M5;
                end
            end
            ffal_pkg::S_F_M3: begin
                o_op    = ffal_pkg::C_F_M3;
                n_state = ffal_pkg::S_F_M5;
            end
            ffal_pkg::S_F_M5: begin
                o_op    = ffal_pkg::C_F_M5;
                n_state = r_from_alloc ? ffal_pkg::S_ALC_RET : ffal_pkg::S_DONE;
            end
            ffal_pkg::S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    o_op    = ffal_pkg::C_LOAD_OUT;
                    n_state = ffal_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffal_pkg::S_IDLE;
            end
        endcase
    end

    // The request side stays closed while reset is held.
    assign o_stall = !i_rst_n || (r_state != ffal_pkg::S_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

### hdl/first_fit_free_list_allocator.sv
// Top level of the first-fit free-list heap allocator.
// Depends on ffal_pkg, ffal_ctrl and ffal_dp.
//
// This block manages a heap of HEAP_UNITS units of UNIT_BYTES bytes each, in the manner of the
// classic first-fit allocator: free blocks sit in an address-ordered circular list that runs
// through a zero-size sentinel, and a roving pointer marks where each search starts. An
// allocate (func 0) rounds request_bytes up to whole units, adds one header unit, and walks
// the list first-fit; a larger block is split and its tail handed out. When the walk comes
// back around, the heap break grows by exactly the units requested (up to the smaller of the
// heap_limit_units register and HEAP_UNITS) and the new block is freed into the list. A free
// (func 1) inserts the block in address order and merges it with free neighbors. Every input
// transfer yields exactly one result transfer: the payload byte offset (0 unless an allocate
// succeeds) and a status of done, null/ignored or out of memory. Timing is set by the single
// read port of the header memory: the walk visits one list node per cycle. An allocate that
// grows the heap adds a full free walk and then restarts its search. The block works on one
// request at a time, but a finished result waits in the output register so the next request
// can be taken while the consumer stalls. The heap-limit register is written through its own
// valid/ready channel; the user must write it only while the block is idle, which the block
// itself does not enforce. The header memory needs no clearing after reset: only headers that
// the allocator itself has written are ever read.
`default_nettype none

module first_fit_free_list_allocator #(
    parameter int unsigned HEAP_UNITS = ffal_pkg::HEAP_UNITS_DEF,
    parameter int unsigned UNIT_BYTES = ffal_pkg::UNIT_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Request channel.
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_func,
    input  wire logic [ffal_pkg::BYTE_W-1:0]   i_request_bytes,
    input  wire logic [ffal_pkg::BYTE_W-1:0]   i_free_offset,
    // Result channel.
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [ffal_pkg::BYTE_W-1:0]   o_payload_offset,
    output logic      [1:0]                    o_status,
    // Heap-limit register write channel.
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ffal_pkg::FW-1:0]       i_cfg_data
);

    ffal_pkg::t_op        op;
    ffal_pkg::t_dp_status st;
    logic                 r_cfg_ready;

    // The register port becomes ready in the cycle after reset releases and stays ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ready <= 1'b0;
        end else begin
            r_cfg_ready <= 1'b1;
        end
    end

    assign o_cfg_ready = r_cfg_ready;

    ffal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_st    (st),
        .o_op    (op)
    );

    ffal_dp #(
        .HEAP_UNITS (HEAP_UNITS),
        .UNIT_BYTES (UNIT_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .o_st             (st),
        .i_func           (i_func),
        .i_request_bytes  (i_request_bytes),
        .i_free_offset    (i_free_offset),
        .i_cfg_we         (i_cfg_valid && r_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_payload_offset (o_payload_offset),
        .o_status         (o_status)
    );

endmodule

`default_nettype wire

### hdl/ffal_checker.sv
// Port-level checks for the allocator, bound to first_fit_free_list_allocator.
// Depends on ffal_pkg for the status codes.
`default_nettype none

module ffal_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [15:0] o_payload_offset,
    input wire logic [1:0]  o_status
);

    // One request at a time: a taken transfer closes the request side.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request side open right after a transfer");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_payload_offset) && $stable(o_status)))
        else $error("stalled result changed");

    a_zero_unless_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ffal_pkg::ST_DONE)) |-> (o_payload_offset == 16'd0))
        else $error("nonzero payload on a failed or null request");

    // A new result only appears at the end of work on a request.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a request in progress");

endmodule

bind first_fit_free_list_allocator ffal_checker u_ffal_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_payload_offset (o_payload_offset),
    .o_status         (o_status)
);

`default_nettype wire
